FILE: rtl/software_timer_table_unit_assert.svh
// Assertion macros shared by the timer table modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef SOFTWARE_TIMER_TABLE_UNIT_ASSERT_SVH
`define SOFTWARE_TIMER_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define STT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer table: same-cycle check failed");

// Next-cycle implication.
`define STT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer table: next-cycle check failed");

`endif

FILE: rtl/stt_pkg.sv
`default_nettype none

package stt_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_SCAN  = 2'd3;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DELAY   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRE_MARGIN = 1'b1;

  localparam logic [31:0] RESET_MIN_DELAY   = 32'd1000000;
  localparam logic [31:0] RESET_FIRE_MARGIN = RESET_MIN_DELAY / 32'd2;

  // Kind of result loaded into the output register.
  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_ARM  = 2'd1,
    EMIT_FIRE = 2'd2,
    EMIT_BEST = 2'd3
  } emit_t;

  typedef struct packed {
    logic  latch_in;
    logic  do_stop;
    logic  arm_write;
    logic  rd_scan;
    logic  scan_clear;
    logic  scan_step;
    logic  buf_drop;
    logic  arm_take;
    logic  best_take;
    logic  clear_present;
    emit_t emit;
    logic  emit_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       slot_ok;
    logic       due;
    logic       scan_last;
    logic       buf_full;
    logic       found;
    logic       hit;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/software_timer_table_unit.sv
// One-shot timer table with next-expiry compare management.
// Input channel: in_valid / in_stall carry operation, slot, time_value and
// current_time; a transfer happens on a clock edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall carry fired, fired_slot,
// program_compare, compare_value and last; last marks the final result of an
// input item. Configuration writes use cfg_valid / cfg_ready (always ready),
// with cfg_index 0 for min_delay and 1 for fire_margin; write them only while
// the block is idle.
// Sequencing: one item is handled at a time by a small sequencer. The scan
// reads one expiry word per cycle from a table with a single read port, unless
// it pauses for a busy output register. A scan that ends with a buffered fired
// slot and a remaining timer emits the fired slot before the new compare value.
// The output register decouples the two sides: a new item is taken while a
// result waits. When out_stall holds a result and another is due, the
// sequencer pauses in place until the register frees up.
// Reset (rst, synchronous) clears all pending and attached flags, the expiry
// table (through per-slot valid bits), the next-timer pointer and restores
// min_delay to 1000000 and fire_margin to 500000.
`default_nettype none

module software_timer_table_unit #(
  parameter int SLOTS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       operation,
  input  logic [3:0]                       slot,
  input  logic [63:0]                      time_value,
  input  logic [63:0]                      current_time,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             fired,
  output logic [3:0]                       fired_slot,
  output logic                             program_compare,
  output logic [63:0]                      compare_value,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data
);

  stt_pkg::cmd_t    cmd;
  stt_pkg::status_t sts;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  // Sequencer: decides what the datapath does in each cycle.
  stt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: expiry table, flags, scan registers and output register.
  stt_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .operation       (operation),
    .slot            (slot),
    .time_value      (time_value),
    .current_time    (current_time),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .fired           (fired),
    .fired_slot      (fired_slot),
    .program_compare (program_compare),
    .compare_value   (compare_value),
    .last            (last)
  );

endmodule

`default_nettype wire

FILE: rtl/stt_ctrl.sv
`default_nettype none
`include "software_timer_table_unit_assert.svh"

module stt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  stt_pkg::status_t  sts,
  output stt_pkg::cmd_t     cmd
);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_PREP       = 9'b000000010,
    S_CALC       = 9'b000000100,
    S_WRITE      = 9'b000001000,
    S_RDPTR      = 9'b000010000,
    S_CHK        = 9'b000100000,
    S_SCAN_START = 9'b001000000,
    S_SCAN       = 9'b010000000,
    S_SCAN_END   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = stt_pkg::EMIT_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_PREP;
        end
      end
      S_PREP: begin
        unique case (sts.op) inside
          stt_pkg::OP_SCAN: begin
            cmd.scan_clear = 1'b1;
            state_next     = S_SCAN_START;
          end
          stt_pkg::OP_STOP: begin
            cmd.do_stop = sts.slot_ok;
            state_next  = S_IDLE;
          end
          stt_pkg::OP_START, stt_pkg::OP_SET: begin
            state_next = sts.slot_ok ? S_CALC : S_IDLE;
          end
        endcase
      end
      S_CALC: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.arm_write = 1'b1;
        state_next    = S_RDPTR;
      end
      S_RDPTR: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        // The pointer read is repeated while the output register is busy.
        if (!sts.hit) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit      = stt_pkg::EMIT_ARM;
          cmd.arm_take  = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SCAN_START: begin
        cmd.rd_scan = 1'b1;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_scan = 1'b1;
        // A due slot replaces the buffered one, which must leave first.
        if (!(sts.due && sts.buf_full && !sts.out_free)) begin
          cmd.scan_step = 1'b1;
          if (sts.due && sts.buf_full) begin
            cmd.emit      = stt_pkg::EMIT_FIRE;
            cmd.emit_last = 1'b0;
          end
          if (sts.scan_last) begin
            state_next = S_SCAN_END;
          end
        end
      end
      S_SCAN_END: begin
        if (sts.found) begin
          if (sts.out_free) begin
            if (sts.buf_full) begin
              cmd.emit      = stt_pkg::EMIT_FIRE;
              cmd.emit_last = 1'b0;
              cmd.buf_drop  = 1'b1;
            end else begin
              cmd.emit      = stt_pkg::EMIT_BEST;
              cmd.best_take = 1'b1;
              state_next    = S_IDLE;
            end
          end
        end else if (!sts.buf_full) begin
          cmd.clear_present = 1'b1;
          state_next        = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit          = stt_pkg::EMIT_FIRE;
          cmd.emit_last     = 1'b1;
          cmd.buf_drop      = 1'b1;
          cmd.clear_present = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `STT_ASSERT_IMP(a_emit_when_free, cmd.emit != stt_pkg::EMIT_NONE, sts.out_free)
  `STT_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire

FILE: rtl/stt_datapath.sv
`default_nettype none
`include "software_timer_table_unit_assert.svh"

module stt_datapath #(
  parameter int SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [stt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic [1:0]                        operation,
  input  logic [3:0]                        slot,
  input  logic [63:0]                       time_value,
  input  logic [63:0]                       current_time,
  input  stt_pkg::cmd_t                     cmd,
  output stt_pkg::status_t                  sts,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic                              fired,
  output logic [3:0]                        fired_slot,
  output logic                              program_compare,
  output logic [63:0]                       compare_value,
  output logic                              last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  logic [31:0]      min_delay;
  logic [31:0]      fire_margin;
  logic [1:0]       op_r;
  logic [3:0]       slot_r;
  logic [63:0]      tv_r;
  logic [63:0]      now_r;
  logic [63:0]      delay_sel;
  logic [63:0]      now_min;
  logic [63:0]      limit;
  logic [63:0]      expiry_new;
  logic [63:0]      expiry_margin;
  logic [63:0]      mem [SLOTS];
  logic [SLOTS-1:0] vld;
  logic [SLOTS-1:0] pending;
  logic [SLOTS-1:0] attached;
  logic [63:0]      rd_data;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_addr;
  logic [63:0]      cur;
  logic [IDX_W-1:0] slot_idx;
  logic             slot_ok;
  logic [IDX_W-1:0] next_slot;
  logic             next_present;
  logic [IDX_W-1:0] cnt;
  logic             scan_last;
  logic             due;
  logic             best_upd;
  logic             found;
  logic [IDX_W-1:0] best_slot;
  logic [63:0]      best_exp;
  logic             buf_full;
  logic [IDX_W-1:0] buf_slot;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_delay   <= stt_pkg::RESET_MIN_DELAY;
      fire_margin <= stt_pkg::RESET_FIRE_MARGIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stt_pkg::CFG_MIN_DELAY:   min_delay   <= cfg_data;
        stt_pkg::CFG_FIRE_MARGIN: fire_margin <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r   <= operation;
      slot_r <= slot;
      tv_r   <= time_value;
      now_r  <= current_time;
    end
  end

  // Registered expiry arithmetic: delay_sel, now_min and limit, then expiry_new, then expiry_margin.
  always_ff @(posedge clk) begin
    delay_sel     <= (tv_r < {32'd0, min_delay}) ? {32'd0, min_delay} : tv_r;
    now_min       <= sat_add(now_r, {32'd0, min_delay});
    limit         <= sat_add(now_r, {32'd0, fire_margin});
    expiry_new    <= (op_r == stt_pkg::OP_START) ? sat_add(now_r, delay_sel)
                                                 : ((tv_r < now_min) ? now_min : tv_r);
    expiry_margin <= sat_add(expiry_new, {32'd0, fire_margin});
  end

  assign slot_idx  = IDX_W'(slot_r);
  assign slot_ok   = (32'(slot_r) < 32'(SLOTS));
  assign scan_last = (cnt == IDX_W'(SLOTS - 1));

  always_comb begin
    if (!cmd.rd_scan) begin
      rd_addr = next_slot;
    end else if (cmd.scan_step && !scan_last) begin
      rd_addr = cnt + IDX_W'(1);
    end else begin
      rd_addr = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.arm_write) begin
      mem[slot_idx] <= expiry_new;
    end
    rd_data <= mem[rd_addr];
  end

  assign cur      = rd_vld ? rd_data : 64'd0;
  assign due      = pending[cnt] && (cur <= limit);
  assign best_upd = pending[cnt] && !due && (!found || (best_exp > cur));
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      pending  <= '0;
      attached <= '0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= vld[rd_addr];
      if (cmd.arm_write) begin
        vld[slot_idx]      <= 1'b1;
        pending[slot_idx]  <= 1'b1;
        attached[slot_idx] <= 1'b1;
      end
      if (cmd.do_stop && attached[slot_idx]) begin
        vld[slot_idx]      <= 1'b0;
        pending[slot_idx]  <= 1'b0;
        attached[slot_idx] <= 1'b0;
      end
      if (cmd.scan_step && due) begin
        pending[cnt] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot    <= '0;
      next_present <= 1'b0;
    end else begin
      if (cmd.arm_take) begin
        next_slot    <= slot_idx;
        next_present <= 1'b1;
      end
      if (cmd.best_take) begin
        next_slot    <= best_slot;
        next_present <= 1'b1;
      end
      if (cmd.clear_present) begin
        next_present <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      found    <= 1'b0;
      buf_full <= 1'b0;
    end else if (cmd.scan_clear) begin
      cnt      <= '0;
      found    <= 1'b0;
      buf_full <= 1'b0;
    end else begin
      if (cmd.buf_drop) begin
        buf_full <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (!scan_last) begin
          cnt <= cnt + IDX_W'(1);
        end
        if (due) begin
          buf_full <= 1'b1;
        end
        if (best_upd) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && due) begin
      buf_slot <= cnt;
    end
    if (cmd.scan_step && best_upd) begin
      best_slot <= cnt;
      best_exp  <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != stt_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      stt_pkg::EMIT_ARM: begin
        fired           <= 1'b0;
        fired_slot      <= 4'd0;
        program_compare <= 1'b1;
        compare_value   <= expiry_new;
        last            <= 1'b1;
      end
      stt_pkg::EMIT_FIRE: begin
        fired           <= 1'b1;
        fired_slot      <= 4'(buf_slot);
        program_compare <= 1'b0;
        compare_value   <= 64'd0;
        last            <= cmd.emit_last;
      end
      stt_pkg::EMIT_BEST: begin
        fired           <= 1'b0;
        fired_slot      <= 4'd0;
        program_compare <= 1'b1;
        compare_value   <= best_exp;
        last            <= 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.op        = op_r;
    sts.slot_ok   = slot_ok;
    sts.due       = due;
    sts.scan_last = scan_last;
    sts.buf_full  = buf_full;
    sts.found     = found;
    sts.hit       = !next_present || (cur > expiry_margin);
    sts.out_free  = out_free;
  end

  `STT_ASSERT_IMP(a_pending_attached, 1'b1, (pending & ~attached) == '0)
  `STT_ASSERT_IMP(a_best_after_fires, cmd.emit == stt_pkg::EMIT_BEST, !buf_full)

endmodule

`default_nettype wire
